/* rtl/vst_pkg.sv */
// ----------------------------------------------------------------------------
// vst_pkg: shared types and helpers of the vertex skinning transform
// Step control word, term kinds, operation and register codes, saturation.
// ----------------------------------------------------------------------------
package vst_pkg;

  localparam int DEF_BONES      = 128;
  localparam int DEF_MAX_BLENDS = 3;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int WORDS_PER_BONE = 12;
  localparam int ORIGIN_WORD    = 9;
  // Running sum width: three products shifted by at least 8 bits plus an origin.
  localparam int SUM_W          = 58;
  localparam int ACC_W          = 48;

  // Operation codes carried in tuser.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_BLEND  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RIGID_MODE     = 2'd0;
  localparam logic [1:0] CFG_RIGID_BONE     = 2'd1;
  localparam logic [1:0] CFG_NORMALS_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PASS_NRM,
    PASS_POS,
    PASS_WGT
  } pass_t;

  typedef enum logic [1:0] {
    TK_ORIGIN,
    TK_PROD,
    TK_WGT8,
    TK_WGT16
  } term_kind_t;

  // One step of the shared multiply-accumulate unit, carried down the pipeline.
  typedef struct packed {
    logic       valid;
    term_kind_t kind;
    pass_t      pass;
    logic [1:0] col;
    logic [1:0] term;   // 0 origin, 1..3 axis row + 1
    logic       first;
    logic       last;
  } step_ctl_t;

  // Reduce a bone index into the table range by compare and subtract.
  function automatic logic [6:0] bone_wrap(input logic [6:0] bone, input int bones);
    int r;
    r = int'(bone);
    for (int k = 6; k >= 0; k--) begin
      if (r >= (bones << k)) begin
        r = r - (bones << k);
      end
    end
    return 7'(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFF_FFFF);
    lo = -hi - SUM_W'(1);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFF_FFFF_FFFF);
    lo = -hi - SUM_W'(1);
    if (x > hi) begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end
    return x[ACC_W-1:0];
  endfunction

endpackage

/* rtl/vst_bone_ram.sv */
// ----------------------------------------------------------------------------
// vst_bone_ram: bone matrix word store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vst_bone_ram #(
  parameter int DEPTH = vst_pkg::DEF_BONES * vst_pkg::WORDS_PER_BONE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/vst_mac.sv */
// ----------------------------------------------------------------------------
// vst_mac: shared multiply-accumulate unit
// Registers one 33x33 product a cycle, then shifts it by term kind and adds
// it into a running column sum.
// ----------------------------------------------------------------------------
module vst_mac #(
  parameter int FRAC_BITS = vst_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vst_pkg::step_ctl_t                in_ctl,
  input  logic signed [32:0]                op_a,
  input  logic signed [32:0]                op_b,
  output logic                              busy,
  output logic                              res_valid,
  output vst_pkg::step_ctl_t                res_ctl,
  output logic signed [vst_pkg::SUM_W-1:0]  res_sum
);

  vst_pkg::step_ctl_t                ctl_q;
  logic signed [65:0]                prod_q;
  logic signed [vst_pkg::SUM_W-1:0]  sum_q;
  logic signed [vst_pkg::SUM_W-1:0]  term;
  logic signed [vst_pkg::SUM_W-1:0]  sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= op_a * op_b;
  end

  // Arithmetic shifts round toward minus infinity.
  always_comb begin
    case (ctl_q.kind)
      vst_pkg::TK_ORIGIN: term = vst_pkg::SUM_W'(prod_q);
      vst_pkg::TK_PROD:   term = vst_pkg::SUM_W'(prod_q >>> FRAC_BITS);
      vst_pkg::TK_WGT8:   term = vst_pkg::SUM_W'(prod_q >>> 8);
      vst_pkg::TK_WGT16:  term = vst_pkg::SUM_W'(prod_q >>> 16);
      default:            term = '0;
    endcase
    sum_next = (ctl_q.first ? '0 : sum_q) + term;
  end

  always_ff @(posedge clk) begin
    if (ctl_q.valid) begin
      sum_q <= sum_next;
    end
  end

  assign busy      = ctl_q.valid;
  assign res_valid = ctl_q.valid && ctl_q.last;
  assign res_ctl   = ctl_q;
  assign res_sum   = sum_next;

endmodule

/* rtl/vertex_skinning_transform.sv */
// ----------------------------------------------------------------------------
// vertex_skinning_transform: linear blend skinning in Q16.16
// Bone matrix table, rigid and skinned vertex transform, normal rotation.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  s_*      in         s_tvalid / s_tready        s_tdata item fields, s_tuser operation
//  m_*      out        m_tvalid / m_tready        m_tdata world pos + normal, m_tuser flag
//  cfg_*    in         cfg_wen (no back-pressure) cfg_index, cfg_data
//
// A matrix word load is written as accepted. A vertex runs a normal pass (if enabled)
// and a position pass, then a weight pass if it starts a blend; a blend item runs a
// position and a weight pass. The single shared multiplier takes one product and one
// bone table read per cycle, with a 2-stage drain between dependent passes.
// Reset (rst, synchronous) clears control, accumulators and the normal hold;
// the bone table stays undefined until loaded.
// A stalled result holds in the output register while the next item is taken;
// a finishing item waits in its last cycle only if that register is still full.
// ----------------------------------------------------------------------------
module vertex_skinning_transform #(
  parameter int BONES      = vst_pkg::DEF_BONES,
  parameter int MAX_BLENDS = vst_pkg::DEF_MAX_BLENDS,
  parameter int FRAC_BITS  = vst_pkg::DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // bone_index[6:0], element_index[10:7], matrix_value[42:11], weight[58:43],
  // blend_count[60:59], pos_x[92:61], pos_y[124:93], pos_z[156:125],
  // nrm_x[188:157], nrm_y[220:189], nrm_z[252:221], zero[255:253]
  input  logic [255:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // world_x[31:0], world_y[63:32], world_z[95:64],
  // world_nx[127:96], world_ny[159:128], world_nz[191:160]
  output logic [191:0] m_tdata,
  // normal_valid[0]
  output logic [0:0]   m_tuser,
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  localparam int DEPTH = BONES * vst_pkg::WORDS_PER_BONE;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic       rigid_mode;
  logic [6:0] rigid_bone;
  logic       normals_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      rigid_mode     <= 1'b0;
      rigid_bone     <= '0;
      normals_enable <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_index)
        vst_pkg::CFG_RIGID_MODE:     rigid_mode     <= cfg_data[0];
        vst_pkg::CFG_RIGID_BONE:     rigid_bone     <= cfg_data;
        vst_pkg::CFG_NORMALS_ENABLE: normals_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input field unpack
  logic [1:0]         in_op;
  logic [6:0]         in_bone;
  logic [3:0]         in_elem;
  logic [31:0]        in_value;
  logic [15:0]        in_weight;
  logic [1:0]         in_count;
  logic signed [31:0] in_pos [3];
  logic signed [31:0] in_nrm [3];

  assign in_op     = s_tuser;
  assign in_bone   = s_tdata[6:0];
  assign in_elem   = s_tdata[10:7];
  assign in_value  = s_tdata[42:11];
  assign in_weight = s_tdata[58:43];
  assign in_count  = s_tdata[60:59];
  assign in_pos[0] = s_tdata[92:61];
  assign in_pos[1] = s_tdata[124:93];
  assign in_pos[2] = s_tdata[156:125];
  assign in_nrm[0] = s_tdata[188:157];
  assign in_nrm[1] = s_tdata[220:189];
  assign in_nrm[2] = s_tdata[252:221];

  // state
  vst_pkg::state_t    state, state_next;
  vst_pkg::pass_t     pass, pass_next;
  logic [1:0]         col, col_next;
  logic [1:0]         term, term_next;
  vst_pkg::step_ctl_t issue;
  vst_pkg::step_ctl_t ctl_b;

  logic signed [31:0]              pos_q [3];
  logic signed [31:0]              nrm_q [3];
  logic [15:0]                     weight_q;
  logic [1:0]                      count_q;
  logic                            is_vertex;
  logic                            need_wgt;
  logic [AW-1:0]                   base_q;
  logic signed [31:0]              tvec [3];
  logic signed [31:0]              nrm_hold [3];
  logic signed [vst_pkg::ACC_W-1:0] acc [3];
  logic [1:0]                      blends_rem;

  logic       accept;
  logic       start_vertex;
  logic       start_blend;
  logic       do_load;
  logic [1:0] count_clip;
  logic [6:0] bone_use;
  logic [AW-1:0] base_in;
  logic [AW-1:0] load_addr;
  logic       emit;
  logic       done_go;
  logic       mac_busy;
  logic       res_valid;
  vst_pkg::step_ctl_t res_ctl;
  logic signed [vst_pkg::SUM_W-1:0] res_sum;

  assign s_tready = (state == vst_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign count_clip   = (int'(in_count) > MAX_BLENDS) ? 2'(MAX_BLENDS) : in_count;
  assign do_load      = accept && (in_op == vst_pkg::OP_LOAD) &&
                        (int'(in_elem) < vst_pkg::WORDS_PER_BONE);
  assign start_vertex = accept && (in_op == vst_pkg::OP_VERTEX);
  assign start_blend  = accept && (in_op == vst_pkg::OP_BLEND) &&
                        !rigid_mode && (blends_rem != 2'd0);

  // row base = wrapped bone * 12
  function automatic logic [AW-1:0] row_base(input logic [6:0] bone);
    logic [6:0] w;
    w = vst_pkg::bone_wrap(bone, BONES);
    return AW'({4'b0, w} * 11'd12);
  endfunction

  assign bone_use  = (start_vertex && rigid_mode) ? rigid_bone : in_bone;
  assign base_in   = row_base(bone_use);
  assign load_addr = base_in + AW'(in_elem);

  assign emit    = is_vertex ? !need_wgt : (blends_rem == 2'd1);
  assign done_go = !emit || !m_tvalid || m_tready;

  // sequencer
  always_comb begin
    state_next = state;
    pass_next  = pass;
    col_next   = col;
    term_next  = term;
    issue      = '0;
    case (state)
      vst_pkg::ST_IDLE: begin
        if (start_vertex) begin
          state_next = vst_pkg::ST_RUN;
          pass_next  = normals_enable ? vst_pkg::PASS_NRM : vst_pkg::PASS_POS;
          col_next   = 2'd0;
          term_next  = normals_enable ? 2'd1 : 2'd0;
        end else if (start_blend) begin
          state_next = vst_pkg::ST_RUN;
          pass_next  = vst_pkg::PASS_POS;
          col_next   = 2'd0;
          term_next  = 2'd0;
        end
      end
      vst_pkg::ST_RUN: begin
        issue.valid = 1'b1;
        issue.pass  = pass;
        issue.col   = col;
        issue.term  = term;
        if (pass == vst_pkg::PASS_WGT) begin
          issue.kind  = is_vertex ? vst_pkg::TK_WGT8 : vst_pkg::TK_WGT16;
          issue.first = 1'b1;
          issue.last  = 1'b1;
        end else begin
          issue.kind  = (term == 2'd0) ? vst_pkg::TK_ORIGIN : vst_pkg::TK_PROD;
          issue.first = (pass == vst_pkg::PASS_NRM) ? (term == 2'd1) : (term == 2'd0);
          issue.last  = (term == 2'd3);
        end
        // advance to the next step
        if (issue.last) begin
          if (col == 2'd2) begin
            if (pass == vst_pkg::PASS_NRM) begin
              pass_next = vst_pkg::PASS_POS;
              col_next  = 2'd0;
              term_next = 2'd0;
            end else begin
              state_next = vst_pkg::ST_DRAIN;
            end
          end else begin
            col_next  = col + 2'd1;
            term_next = (pass == vst_pkg::PASS_NRM) ? 2'd1 : 2'd0;
          end
        end else begin
          term_next = term + 2'd1;
        end
      end
      vst_pkg::ST_DRAIN: begin
        if (!ctl_b.valid && !mac_busy) begin
          if (pass == vst_pkg::PASS_POS && need_wgt) begin
            state_next = vst_pkg::ST_RUN;
            pass_next  = vst_pkg::PASS_WGT;
            col_next   = 2'd0;
            term_next  = 2'd0;
          end else begin
            state_next = vst_pkg::ST_DONE;
          end
        end
      end
      vst_pkg::ST_DONE: begin
        if (done_go) begin
          state_next = vst_pkg::ST_IDLE;
        end
      end
      default: state_next = vst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vst_pkg::ST_IDLE;
      pass  <= vst_pkg::PASS_POS;
      col   <= '0;
      term  <= '0;
      ctl_b <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      col   <= col_next;
      term  <= term_next;
      ctl_b <= issue;
    end
  end

  // bone table
  logic [3:0]    rd_word;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  assign rd_word = (term == 2'd0) ? (4'(vst_pkg::ORIGIN_WORD) + {2'b0, col})
                                  : ({2'b0, term - 2'd1} * 4'd3 + {2'b0, col});
  assign rd_addr = base_q + AW'(rd_word);

  vst_bone_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .wen   (do_load),
    .waddr (load_addr),
    .wdata (in_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // operand select for the step whose table word just arrived
  logic signed [32:0] op_a;
  logic signed [32:0] op_b;
  logic [1:0]         row;

  assign row = ctl_b.term - 2'd1;

  always_comb begin
    case (ctl_b.kind)
      vst_pkg::TK_ORIGIN: begin
        op_a = 33'sd1;
        op_b = {rd_data[31], rd_data};
      end
      vst_pkg::TK_PROD: begin
        op_a = (ctl_b.pass == vst_pkg::PASS_NRM) ? {nrm_q[row][31], nrm_q[row]}
                                                 : {pos_q[row][31], pos_q[row]};
        op_b = {rd_data[31], rd_data};
      end
      default: begin
        op_a = {tvec[ctl_b.col][31], tvec[ctl_b.col]};
        op_b = {17'b0, weight_q};
      end
    endcase
  end

  vst_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl_b),
    .op_a      (op_a),
    .op_b      (op_b),
    .busy      (mac_busy),
    .res_valid (res_valid),
    .res_ctl   (res_ctl),
    .res_sum   (res_sum)
  );

  // item latch and transform payload
  always_ff @(posedge clk) begin
    if (start_vertex || start_blend) begin
      pos_q    <= in_pos;
      nrm_q    <= in_nrm;
      weight_q <= in_weight;
      base_q   <= base_in;
    end
    if (res_valid && res_ctl.pass == vst_pkg::PASS_POS) begin
      tvec[res_ctl.col] <= vst_pkg::sat32(res_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_vertex  <= 1'b0;
      need_wgt   <= 1'b0;
      count_q    <= '0;
      blends_rem <= '0;
      for (int i = 0; i < 3; i++) begin
        nrm_hold[i] <= '0;
        acc[i]      <= '0;
      end
    end else begin
      if (start_vertex) begin
        is_vertex <= 1'b1;
        count_q   <= count_clip;
        need_wgt  <= !rigid_mode && (count_clip != 2'd0);
        if (!normals_enable) begin
          for (int i = 0; i < 3; i++) begin
            nrm_hold[i] <= '0;
          end
        end
      end else if (start_blend) begin
        is_vertex <= 1'b0;
        need_wgt  <= 1'b1;
      end
      if (res_valid) begin
        case (res_ctl.pass)
          vst_pkg::PASS_NRM: nrm_hold[res_ctl.col] <= vst_pkg::sat32(res_sum);
          vst_pkg::PASS_WGT: begin
            if (res_ctl.kind == vst_pkg::TK_WGT8) begin
              acc[res_ctl.col] <= vst_pkg::sat48(res_sum);
            end else begin
              acc[res_ctl.col] <= vst_pkg::sat48(
                vst_pkg::SUM_W'(acc[res_ctl.col]) + res_sum);
            end
          end
          default: ;
        endcase
      end
      if (state == vst_pkg::ST_DONE && done_go) begin
        if (is_vertex) begin
          if (emit) begin
            blends_rem <= '0;
            for (int i = 0; i < 3; i++) begin
              acc[i] <= '0;
            end
          end else begin
            blends_rem <= count_q;
          end
        end else begin
          blends_rem <= blends_rem - 2'd1;
        end
      end
    end
  end

  // output register: load a finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == vst_pkg::ST_DONE && done_go && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == vst_pkg::ST_DONE && done_go && emit) begin
      for (int i = 0; i < 3; i++) begin
        m_tdata[32*i +: 32] <= is_vertex ? tvec[i]
                                         : vst_pkg::sat32(vst_pkg::SUM_W'(acc[i]));
        m_tdata[96 + 32*i +: 32] <= nrm_hold[i];
      end
      m_tuser[0] <= normals_enable;
    end
  end

  // checks
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    int'(blends_rem) <= MAX_BLENDS)
    else $error("pending blend count beyond limit");

  a_result_in_flight: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == vst_pkg::ST_RUN || state == vst_pkg::ST_DRAIN))
    else $error("unit result outside a transform");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    (state == vst_pkg::ST_DONE) |-> (!ctl_b.valid && !mac_busy))
    else $error("item finished with steps still in the pipeline");

  a_beat_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == vst_pkg::ST_DONE))
    else $error("result beat raised outside the finish cycle");

  a_wgt_after_pos: assert property (@(posedge clk) disable iff (rst)
    (issue.valid && issue.pass == vst_pkg::PASS_WGT) |-> !ctl_b.valid && !mac_busy
      || $past(issue.valid && issue.pass == vst_pkg::PASS_WGT))
    else $error("weight step issued before position pass drained");

endmodule
